### sv/assert_macros.svh
// assertion helpers; they expect clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Types and codes shared by the deque sort/dedupe engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

  localparam int OCC_BITS = 6;

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SORT       = 3'd4;
  localparam logic [2:0] ACT_DEDUPE     = 3'd5;
  localparam logic [2:0] ACT_DUMP       = 3'd6;
  localparam logic [2:0] ACT_NOP        = 3'd7;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   element;
    logic [OCC_BITS-1:0]  occupancy;
    logic                 final_flag;
  } res_t;

endpackage

`default_nettype wire

### sv/dsd_ram.sv
// ----------------------------------------------------------------------------
// dsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/deque_sort_dedup_engine_unit.sv
// ----------------------------------------------------------------------------
// deque_sort_dedup_engine_unit
// Bounded double-ended queue with in-place sort, duplicate removal and dump.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken when start is high and busy is low;
// request carries the action and the value to push. Each result appears on
// result for exactly one cycle with done high; there is no back-pressure.
// Push, pop and no-op give one result in the cycle after acceptance and busy
// stays low, so one command per cycle is sustained.
// Dump of n elements: one result per element on consecutive cycles, each
// from the registered read of the store, final_flag on the last one.
// Sort of n elements: streaming bubble passes over the store, each pass one
// element shorter than the last, carrying the larger word towards the back.
// Dedupe of n elements: each element is compared against the survivors read
// back from the store in turn, until a match or the last survivor is reached.
// These walks are bounded by the single read port of the element store.
// Reset clears the front pointer and the count; the store itself is not
// cleared, since an entry is only read after it has been written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module deque_sort_dedup_engine_unit #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire dsd_pkg::req_t request,
  output logic              done,
  output dsd_pkg::res_t     result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SFIRST = 9'b000000010,
    S_SSTEP  = 9'b000000100,
    S_STAIL  = 9'b000001000,
    S_DCAND  = 9'b000010000,
    S_DSCAN  = 9'b000100000,
    S_DKEEP  = 9'b001000000,
    S_DNEXT  = 9'b010000000,
    S_DUMP   = 9'b100000000
  } state_t;

  state_t                       state;
  logic [IW-1:0]                front;
  logic [CW-1:0]                count;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                lim;
  logic [IW-1:0]                jdx;
  logic [CW-1:0]                nsurv;
  logic signed [WORD_BITS-1:0]  held;
  logic [WORD_BITS-1:0]         cand;

  logic                         we;
  logic [IW-1:0]                waddr;
  logic [WORD_BITS-1:0]         wdata;
  logic [IW-1:0]                raddr;
  logic [WORD_BITS-1:0]         rdata;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [IW-1:0]                front_dec;
  logic [IW-1:0]                front_inc;
  logic signed [31:0]           in_val;
  logic [WORD_BITS-1:0]         push_word;
  logic signed [WORD_BITS-1:0]  rsig;
  logic signed [63:0]           rext;
  logic                         lt;

  // logical to physical slot
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] f, input logic [IW-1:0] l);
    logic [IW:0] s;
    s = {1'b0, f} + {1'b0, l};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign in_val    = request.value;
  assign push_word = WORD_BITS'(64'(in_val));
  assign rsig      = rdata;
  assign rext      = 64'(rsig);
  assign lt        = rsig < held;

  // element store
  dsd_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = push_word;
    raddr = phys(front, '0);
    case (state)
      S_IDLE: begin
        if (accept && !full) begin
          if (request.action == dsd_pkg::ACT_PUSH_FRONT) begin
            we    = 1'b1;
            waddr = front_dec;
          end else if (request.action == dsd_pkg::ACT_PUSH_BACK) begin
            we    = 1'b1;
            waddr = phys(front, count[IW-1:0]);
          end
        end
      end
      S_SFIRST: begin
        raddr = phys(front, idx);
      end
      S_SSTEP: begin
        we    = 1'b1;
        waddr = phys(front, idx - 1'b1);
        wdata = lt ? rdata : held;
        raddr = phys(front, idx + 1'b1);
      end
      S_STAIL: begin
        we    = 1'b1;
        waddr = phys(front, lim);
        wdata = held;
      end
      S_DCAND: begin
        raddr = phys(front, '0);
      end
      S_DSCAN: begin
        raddr = phys(front, jdx + 1'b1);
      end
      S_DKEEP: begin
        we    = 1'b1;
        waddr = phys(front, nsurv[IW-1:0]);
        wdata = cand;
      end
      S_DNEXT: begin
        raddr = phys(front, idx + 1'b1);
      end
      S_DUMP: begin
        raddr = phys(front, idx + 1'b1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            result.status     <= dsd_pkg::ST_DONE;
            result.element    <= '0;
            result.occupancy  <= dsd_pkg::OCC_BITS'(count);
            result.final_flag <= 1'b1;
            done              <= 1'b1;
            case (request.action)
              dsd_pkg::ACT_PUSH_FRONT, dsd_pkg::ACT_PUSH_BACK: begin
                if (full) begin
                  result.status <= dsd_pkg::ST_FULL;
                end else begin
                  if (request.action == dsd_pkg::ACT_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                  count            <= count + 1'b1;
                  result.occupancy <= dsd_pkg::OCC_BITS'(count + 1'b1);
                end
              end
              dsd_pkg::ACT_POP_FRONT, dsd_pkg::ACT_POP_BACK: begin
                if (empty) begin
                  result.status <= dsd_pkg::ST_EMPTY;
                end else begin
                  if (request.action == dsd_pkg::ACT_POP_FRONT) begin
                    front <= front_inc;
                  end
                  count            <= count - 1'b1;
                  result.occupancy <= dsd_pkg::OCC_BITS'(count - 1'b1);
                end
              end
              dsd_pkg::ACT_SORT: begin
                if (count > CW'(1)) begin
                  done  <= 1'b0;
                  lim   <= IW'(count - 1'b1);
                  idx   <= IW'(1);
                  state <= S_SFIRST;
                end
              end
              dsd_pkg::ACT_DEDUPE: begin
                if (!empty) begin
                  done  <= 1'b0;
                  idx   <= '0;
                  nsurv <= '0;
                  state <= S_DCAND;
                end
              end
              dsd_pkg::ACT_DUMP: begin
                if (empty) begin
                  result.status <= dsd_pkg::ST_EMPTY;
                end else begin
                  done  <= 1'b0;
                  idx   <= '0;
                  state <= S_DUMP;
                end
              end
              default: begin
                result.status <= dsd_pkg::ST_DONE;
              end
            endcase
          end
        end
        // sort: carry the larger word along the pass
        S_SFIRST: begin
          held  <= rsig;
          state <= S_SSTEP;
        end
        S_SSTEP: begin
          if (!lt) begin
            held <= rsig;
          end
          if (idx == lim) begin
            state <= S_STAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_STAIL: begin
          if (lim == IW'(1)) begin
            result.status     <= dsd_pkg::ST_DONE;
            result.element    <= '0;
            result.occupancy  <= dsd_pkg::OCC_BITS'(count);
            result.final_flag <= 1'b1;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else begin
            lim   <= lim - 1'b1;
            idx   <= IW'(1);
            state <= S_SFIRST;
          end
        end
        // dedupe: compare candidate against survivors
        S_DCAND: begin
          cand  <= rdata;
          jdx   <= '0;
          state <= (nsurv == '0) ? S_DKEEP : S_DSCAN;
        end
        S_DSCAN: begin
          if (rdata == cand) begin
            state <= S_DNEXT;
          end else if (CW'(jdx) + 1'b1 == nsurv) begin
            state <= S_DKEEP;
          end else begin
            jdx <= jdx + 1'b1;
          end
        end
        S_DKEEP: begin
          nsurv <= nsurv + 1'b1;
          state <= S_DNEXT;
        end
        S_DNEXT: begin
          if (CW'(idx) + 1'b1 == count) begin
            count             <= nsurv;
            result.status     <= dsd_pkg::ST_DONE;
            result.element    <= '0;
            result.occupancy  <= dsd_pkg::OCC_BITS'(nsurv);
            result.final_flag <= 1'b1;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DCAND;
          end
        end
        // dump: one element per cycle
        S_DUMP: begin
          result.status     <= dsd_pkg::ST_DONE;
          result.element    <= rext[31:0];
          result.occupancy  <= dsd_pkg::OCC_BITS'(count);
          result.final_flag <= (CW'(idx) + 1'b1 == count);
          done              <= 1'b1;
          if (CW'(idx) + 1'b1 == count) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_IMPLIES(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_quick_result, accept && (request.action <= dsd_pkg::ACT_POP_BACK),
               done && result.final_flag)
  `ASSERT_NEXT(a_dump_burst, done && !result.final_flag, done)
  `ASSERT_IMPLIES(a_surv_bound, state == S_DKEEP || state == S_DSCAN, nsurv < count)

endmodule

`default_nettype wire
